>>> rtl/five_point_average_stencil_defines.svh
// assertion macros shared by the checker files of the stencil block
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef FIVE_POINT_AVERAGE_STENCIL_DEFINES_SVH
`define FIVE_POINT_AVERAGE_STENCIL_DEFINES_SVH

// property that must hold at every edge outside reset
`define FPAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define FPAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fpas_pkg.sv
// types and constants of the five point average stencil
// no dependencies; imported by fpas_front, fpas_cmdq, fpas_back and the top level
package fpas_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned FW_W      = 11;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [FW_W-1:0]  FW_RESET = FW_W'(640);
  localparam logic [ROW_W-1:0] FH_RESET = ROW_W'(480);

  // register index taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // divide by five: floor(mag * RECIP >> RECIP_SHIFT) is exact for mag < 2**MAG_W
  localparam int unsigned SUM_W       = DATA_W + 3;
  localparam int unsigned MAG_W       = DATA_W + 2;
  localparam int unsigned LO_W        = MAG_W / 2;
  localparam int unsigned HI_W        = MAG_W - LO_W;
  localparam int unsigned RECIP_SHIFT = MAG_W + 3;
  localparam int unsigned RECIP_W     = MAG_W + 1;
  localparam longint unsigned RECIP_VAL = ((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int unsigned PL_W   = LO_W + RECIP_W;
  localparam int unsigned PH_W   = HI_W + RECIP_W;
  localparam int unsigned PROD_W = MAG_W + RECIP_W;

  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [FW_W-1:0]  width;
    logic [ROW_W-1:0] height;
  } extent_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] centre;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     interior;
    logic                     has_filt;
    logic                     has_copy;
    logic                     done;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              done;
  } res_t;

endpackage

>>> rtl/fpas_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module fpas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the value held before a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/fpas_front.sv
// front end: raster counters, pixel classification and the two line buffers
// depends on fpas_pkg and fpas_ram
module fpas_front #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fpas_pkg::extent_t       extent_i,
  input  logic                    push_i,
  input  logic [31:0]             sample_i,
  input  logic [fpas_pkg::CQ_AW:0] cq_level_i,
  output logic                    full_o,
  output logic                    cmd_valid_o,
  output fpas_pkg::cmd_t          cmd_o
);
  import fpas_pkg::*;

  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] col_q, cur_col;
  logic [ROW_W-1:0] row_q, cur_row;
  logic [FW_W-1:0]  col_inc;
  logic [ROW_W:0]   row_inc;
  logic             restart, last_col, last_row, accept;
  logic [CQ_AW:0]   level;
  logic             s1_valid_q;
  cmd_t             s1_q, s1_d;
  logic signed [SAMPLE_BITS-1:0] x_s, centre_rd, right_rd, up_rd;
  logic signed [DATA_W-1:0]      left_q;

  always_comb begin
    if (extent_i.width == '0) begin
      w_eff = FW_W'(1);
    end else if (extent_i.width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = extent_i.width;
    end
    h_eff = (extent_i.height == '0) ? ROW_W'(1) : extent_i.height;
  end

  assign restart  = (FW_W'(col_q) >= w_eff) || (row_q >= h_eff);
  assign cur_col  = restart ? '0 : col_q;
  assign cur_row  = restart ? '0 : row_q;
  assign col_inc  = FW_W'(cur_col) + FW_W'(1);
  assign row_inc  = {1'b0, cur_row} + (ROW_W+1)'(1);
  assign last_col = col_inc >= w_eff;
  assign last_row = row_inc == {1'b0, h_eff};

  assign level  = cq_level_i + (CQ_AW+1)'(s1_valid_q);
  assign full_o = level >= (CQ_AW+1)'(CQ_DEPTH);
  assign accept = push_i && !full_o;
  assign x_s    = sample_i[SAMPLE_BITS-1:0];

  always_comb begin
    s1_d          = '0;
    s1_d.x        = DATA_W'(x_s);
    s1_d.row      = cur_row;
    s1_d.col      = cur_col;
    s1_d.has_filt = cur_row != '0;
    s1_d.interior = (cur_row != '0) && (cur_row != ROW_W'(1)) && (cur_col != '0) && !last_col;
    s1_d.has_copy = last_row;
    s1_d.done     = last_row && last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : ROW_W'(row_inc);
        end else begin
          col_q <= COL_W'(col_inc);
          row_q <= cur_row;
        end
      end
    end
  end

  // left neighbour is the centre read by the previous pixel of the row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q) begin
      left_q <= cmd_o.centre;
    end
  end

  // two copies of the newest row give the centre and right reads
  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev_a (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cur_col),
    .wdata_i (sample_i[SAMPLE_BITS-1:0]),
    .raddr_i (cur_col),
    .rdata_o (centre_rd)
  );

  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev_b (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cur_col),
    .wdata_i (sample_i[SAMPLE_BITS-1:0]),
    .raddr_i (cur_col + COL_W'(1)),
    .rdata_o (right_rd)
  );

  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_q.col),
    .wdata_i (centre_rd),
    .raddr_i (cur_col),
    .rdata_o (up_rd)
  );

  always_comb begin
    cmd_o        = s1_q;
    cmd_o.centre = DATA_W'(centre_rd);
    cmd_o.right  = DATA_W'(right_rd);
    cmd_o.up     = DATA_W'(up_rd);
    cmd_o.left   = left_q;
  end

  assign cmd_valid_o = s1_valid_q && (s1_q.has_filt || s1_q.has_copy);

endmodule

>>> rtl/fpas_cmdq.sv
// short command queue between the front end and the arithmetic back end
// depends on fpas_pkg
module fpas_cmdq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  fpas_pkg::cmd_t           cmd_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output fpas_pkg::cmd_t           cmd_o,
  output logic [fpas_pkg::CQ_AW:0] level_o
);
  import fpas_pkg::*;

  cmd_t             mem_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wptr_q, rptr_q;
  logic [CQ_AW:0]   count_q;
  logic             wr, rd;

  assign wr      = push_i && (count_q != (CQ_AW+1)'(CQ_DEPTH));
  assign rd      = pop_i && valid_o;
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rptr_q];
  assign level_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr) begin
        wptr_q <= wptr_q + CQ_AW'(1);
      end
      if (rd) begin
        rptr_q <= rptr_q + CQ_AW'(1);
      end
      count_q <= count_q + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/fpas_back.sv
// back end: five point sum, divide by five and the result queue
// depends on fpas_pkg
module fpas_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  fpas_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fpas_pkg::res_t res_o
);
  import fpas_pkg::*;

  logic [1:0]       nres;
  logic             issue;
  logic [OQ_CW-1:0] committed_q;

  logic b1_valid_q, b2_valid_q, b3_valid_q, b4_valid_q;
  cmd_t b1_q, b2_q, b3_q, b4_q;

  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic                    neg_q, neg4_q;
  logic [PL_W-1:0]         pl_d, pl_q;
  logic [PH_W-1:0]         ph_d, ph_q;
  logic [PROD_W-1:0]       prod;
  logic [DATA_W-1:0]       quot, filt_val;
  res_t                    filt_res, copy_res, e0, e1;

  res_t             oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_q, rptr_q;
  logic [OQ_CW-1:0] count_q;
  logic [1:0]       wr_n;
  logic             rd;

  // credit check reserves result slots before an item enters the pipe
  assign nres  = 2'(cmd_i.has_filt) + 2'(cmd_i.has_copy);
  assign issue = cmd_valid_i &&
                 ((OQ_CW+1)'(committed_q) + (OQ_CW+1)'(nres) <= (OQ_CW+1)'(OQ_DEPTH));
  assign cmd_pop_o = issue;

  assign sum_d = SUM_W'(b1_q.x) + SUM_W'(b1_q.centre) + SUM_W'(b1_q.up) +
                 SUM_W'(b1_q.left) + SUM_W'(b1_q.right);
  assign mag_d = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  assign pl_d  = {{RECIP_W{1'b0}}, mag_q[LO_W-1:0]} * {{LO_W{1'b0}}, RECIP};
  assign ph_d  = {{RECIP_W{1'b0}}, mag_q[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, RECIP};
  assign prod  = (PROD_W'(ph_q) << LO_W) + PROD_W'(pl_q);
  assign quot  = prod[RECIP_SHIFT +: DATA_W];

  always_comb begin
    if (b4_q.interior) begin
      filt_val = neg4_q ? (~quot + DATA_W'(1)) : quot;
    end else begin
      filt_val = b4_q.centre;
    end
    filt_res.value = filt_val;
    filt_res.row   = b4_q.row - ROW_W'(1);
    filt_res.col   = b4_q.col;
    filt_res.done  = 1'b0;
    copy_res.value = b4_q.x;
    copy_res.row   = b4_q.row;
    copy_res.col   = b4_q.col;
    copy_res.done  = b4_q.done;
    e0 = b4_q.has_filt ? filt_res : copy_res;
    e1 = copy_res;
    wr_n = b4_valid_q ? (2'(b4_q.has_filt) + 2'(b4_q.has_copy)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      committed_q <= '0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
    end else begin
      b1_valid_q  <= issue;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      committed_q <= committed_q + (issue ? OQ_CW'(nres) : '0) - OQ_CW'(rd);
      wptr_q      <= wptr_q + OQ_AW'(wr_n);
      if (rd) begin
        rptr_q <= rptr_q + OQ_AW'(1);
      end
      count_q <= count_q + OQ_CW'(wr_n) - OQ_CW'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_q <= cmd_i;
    end
    b2_q   <= b1_q;
    sum_q  <= sum_d;
    b3_q   <= b2_q;
    mag_q  <= mag_d;
    neg_q  <= sum_q[SUM_W-1];
    b4_q   <= b3_q;
    pl_q   <= pl_d;
    ph_q   <= ph_d;
    neg4_q <= neg_q;
    if (wr_n != 2'd0) begin
      oq_q[wptr_q] <= e0;
    end
    if (wr_n == 2'd2) begin
      oq_q[wptr_q + OQ_AW'(1)] <= e1;
    end
  end

  assign empty_o = count_q == '0;
  assign rd      = pop_i && !empty_o;
  assign res_o   = oq_q[rptr_q];

endmodule

>>> rtl/five_point_average_stencil.sv
// five point average stencil over a raster-order frame of signed samples.
// input channel: push/full, one sample accepted at an edge with push high and full low.
// result channel: empty/pop, the oldest result sits on value_o, out_row_o, out_column_o
// and frame_done_o while empty is low and is taken at an edge with pop high.
// config: apb registers frame_width at 0x0 and frame_height at 0x4, written only when
// idle by the user; the block does not enforce it. pixel (r,c) releases result
// (r-1,c); on the last row it also releases (r,c) itself, so an item gives zero, one
// or two results. border pixels pass through, interior pixels become the five point
// sum divided by five, truncated toward zero. a result passes the front stage, command
// queue, b1 to b4 and result queue. throughput: one sample per cycle while full is low,
// set by the line buffer read at the front end; on the last row the result port at one
// transfer per cycle sets the pace instead. a stalled receiver fills the result queue
// (8 entries) and then the command queue (4 entries), after which full rises; nothing
// is dropped. reset clears the counters and queues and loads 640 x 480; line buffers
// are not cleared and need no clearing pass, so items are taken right after reset.
// depends on fpas_pkg, fpas_front, fpas_cmdq, fpas_back
module five_point_average_stencil #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [31:0]                    sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [31:0]                    value_o,
  output logic [15:0]                    out_row_o,
  output logic [9:0]                     out_column_o,
  output logic                           frame_done_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpas_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import fpas_pkg::*;

  logic [FW_W-1:0]  fw_q;
  logic [ROW_W-1:0] fh_q;
  logic             cfg_wr;
  extent_t          extent;
  cmd_t             front_cmd, head_cmd;
  logic             front_valid, head_valid, head_pop;
  logic [CQ_AW:0]   cq_level;
  res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(fw_q);
      REG_FRAME_HEIGHT: prdata = 32'(fh_q);
      default:          prdata = '0;
    endcase
  end

  assign extent.width  = fw_q;
  assign extent.height = fh_q;

  fpas_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .extent_i    (extent),
    .push_i      (push),
    .sample_i    (sample_i),
    .cq_level_i  (cq_level),
    .full_o      (full),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  fpas_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .cmd_i   (front_cmd),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .level_o (cq_level)
  );

  fpas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign value_o      = res.value;
  assign out_row_o    = res.row;
  assign out_column_o = res.col;
  assign frame_done_o = res.done;

endmodule

>>> rtl/fpas_chk.sv
// port-level checker for the stencil block and its bind to the top level
// depends on five_point_average_stencil_defines.svh
`include "five_point_average_stencil_defines.svh"

module fpas_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] value_o,
  input logic [15:0] out_row_o,
  input logic [9:0]  out_column_o,
  input logic        frame_done_o
);

  localparam logic [5:0] DRAIN_LIMIT = 6'd40;

  logic       saw_done_q;
  logic [5:0] quiet_q;
  logic       quiet;

  // no input transfer and no stalled result
  assign quiet = !(push && !full) && (empty || pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_done_q <= 1'b0;
      quiet_q    <= '0;
    end else begin
      if (pop && !empty) begin
        saw_done_q <= frame_done_o;
      end
      if (!quiet) begin
        quiet_q <= '0;
      end else if (quiet_q != DRAIN_LIMIT) begin
        quiet_q <= quiet_q + 6'd1;
      end
    end
  end

  `FPAS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(value_o) && $stable(out_row_o) && $stable(out_column_o) && $stable(frame_done_o), "stalled result changed")
  `FPAS_ASSERT(a_frame_restart, !(!empty && saw_done_q) || (out_row_o == 16'd0 && out_column_o == 10'd0), "result after frame end is not at the origin")
  `FPAS_ASSERT(a_drains, !(quiet_q == DRAIN_LIMIT) || (empty && !full), "block did not drain")

endmodule

bind five_point_average_stencil fpas_chk u_fpas_chk (.*);
